FILE: rtl/assert_macros.svh
// Assertion helpers. Each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define ESCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/escp_pkg.sv
package escp_pkg;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_LOOKUP  = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_EVICT   = 6'b010000,
    ST_INSTALL = 6'b100000
  } state_t;

endpackage

FILE: rtl/enhanced_second_chance_pager_unit.sv
// Channel  Handshake             Beat fields
// -------  --------------------  ---------------------------------------------
// in       in_valid / in_ready   page_no, is_write
// out      out_valid / out_ready frame_no, hit, evicted, evict_page, write_back
//
// Steps: a hit or a fill of a free frame does a page map read, then an update.
//   A miss with all frames full adds the clock scan, one frame per cycle (the
//   fourth round always stops at the hand), then the owner read and the page
//   map rewrite.
// Reset: a clearing pass writes every page map entry invalid, with in_ready
//   low until it ends.
// Stalls: one result register; the next beat is taken while a result waits,
//   and the block holds in its final step until the result register is free.
`include "assert_macros.svh"

module enhanced_second_chance_pager_unit #(
  parameter int FRAMES = 8,
  parameter int PAGES  = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [$clog2(PAGES)-1:0]   page_no,
  input  logic                       is_write,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(FRAMES)-1:0]  frame_no,
  output logic                       hit,
  output logic                       evicted,
  output logic [$clog2(PAGES)-1:0]   evict_page,
  output logic                       write_back
);

  localparam int PW = $clog2(PAGES);
  localparam int FW = $clog2(FRAMES);
  localparam logic [PW:0]   PAGES_W   = (PW+1)'(PAGES);
  localparam logic [FW:0]   FRAMES_W  = (FW+1)'(FRAMES);
  localparam logic [FW-1:0] LAST_F    = FW'(FRAMES - 1);
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);

  function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f);
    next_frame = (f == LAST_F) ? '0 : f + 1'b1;
  endfunction

  // Page map: {valid, frame}. Frame owner: resident page per frame.
  logic [FW:0]   page_map    [PAGES];
  logic [PW-1:0] frame_owner [FRAMES];

  escp_pkg::state_t state;

  logic [FRAMES-1:0] frame_ref;
  logic [FRAMES-1:0] frame_dirty;
  logic [FW-1:0]     clock_hand;
  logic [FW:0]       frames_used;
  logic [PW-1:0]     clr_idx;

  logic [PW-1:0] page_q;
  logic          wr_q;
  logic [FW-1:0] scan_f;
  logic [FW-1:0] scan_cnt;
  logic [1:0]    scan_pass;
  logic [FW-1:0] victim;
  logic [PW-1:0] vic_page;
  logic          vic_wb;

  logic [FW:0]   pm_rd;
  logic [PW-1:0] own_rd;

  // Combinational controls
  logic          accept;
  logic [PW-1:0] page_in;
  logic          out_free;
  logic          out_load;
  logic          pm_vld;
  logic [FW-1:0] pm_frame;
  logic          fill_ok;
  logic [FW-1:0] fill_f;
  logic          scan_take;
  logic          scan_wrap;
  logic          pm_we;
  logic [PW-1:0] pm_wa;
  logic [FW:0]   pm_wd;
  logic          own_we;
  logic [FW-1:0] own_wa;
  logic          own_re;
  logic [FW-1:0] own_ra;

  assign in_ready = (state == escp_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  // page_no is below 2*PAGES, so one compare-subtract reduces it
  assign page_in  = ({1'b0, page_no} >= PAGES_W) ? page_no - PAGES_W[PW-1:0] : page_no;
  assign out_free = !out_valid || out_ready;
  assign pm_vld   = pm_rd[FW];
  assign pm_frame = pm_rd[FW-1:0];
  assign fill_ok  = frames_used < FRAMES_W;
  assign fill_f   = frames_used[FW-1:0];
  // A new result goes into the output register this cycle
  assign out_load = out_free &&
                    (((state == escp_pkg::ST_LOOKUP) && (pm_vld || fill_ok)) ||
                     (state == escp_pkg::ST_INSTALL));

  // Scan takes a frame with ref 0 and dirty matching the pass parity.
  assign scan_take = (state == escp_pkg::ST_SCAN) && !frame_ref[scan_f] &&
                     (frame_dirty[scan_f] == scan_pass[0]);
  assign scan_wrap = (scan_cnt == LAST_F);

  always_comb begin
    pm_we  = 1'b0;
    pm_wa  = page_q;
    pm_wd  = '0;
    own_we = 1'b0;
    own_wa = fill_f;
    own_re = 1'b0;
    own_ra = clock_hand;
    unique case (state)
      escp_pkg::ST_CLEAR: begin
        pm_we = 1'b1;
        pm_wa = clr_idx;
      end
      escp_pkg::ST_LOOKUP: begin
        if (!pm_vld && fill_ok && out_free) begin
          pm_we  = 1'b1;
          pm_wd  = {1'b1, fill_f};
          own_we = 1'b1;
        end
      end
      escp_pkg::ST_SCAN: begin
        if (scan_take) begin
          own_re = 1'b1;
          own_ra = scan_f;
        end else if (scan_wrap && scan_pass == 2'd3) begin
          own_re = 1'b1;   // unreachable fallback: take the hand
        end
      end
      escp_pkg::ST_EVICT: begin
        pm_we = 1'b1;      // drop old page's mapping
        pm_wa = own_rd;
      end
      escp_pkg::ST_INSTALL: begin
        if (out_free) begin
          pm_we  = 1'b1;
          pm_wd  = {1'b1, victim};
          own_we = 1'b1;
          own_wa = victim;
        end
      end
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (accept) begin
      pm_rd <= page_map[page_in];
    end
    if (pm_we) begin
      page_map[pm_wa] <= pm_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (own_re) begin
      own_rd <= frame_owner[own_ra];
    end
    if (own_we) begin
      frame_owner[own_wa] <= page_q;
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= escp_pkg::ST_CLEAR;
      clr_idx     <= '0;
      frame_ref   <= '0;
      frame_dirty <= '0;
      clock_hand  <= '0;
      frames_used <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        escp_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_PAGE) begin
            state <= escp_pkg::ST_IDLE;
          end
        end
        escp_pkg::ST_IDLE: begin
          if (accept) begin
            page_q <= page_in;
            wr_q   <= is_write;
            state  <= escp_pkg::ST_LOOKUP;
          end
        end
        escp_pkg::ST_LOOKUP: begin
          if (pm_vld) begin
            if (out_free) begin
              frame_ref[pm_frame] <= 1'b1;
              if (wr_q) begin
                frame_dirty[pm_frame] <= 1'b1;
              end
              out_valid   <= 1'b1;
              frame_no    <= pm_frame;
              hit         <= 1'b1;
              evicted     <= 1'b0;
              evict_page  <= '0;
              write_back  <= 1'b0;
              state       <= escp_pkg::ST_IDLE;
            end
          end else if (fill_ok) begin
            if (out_free) begin
              frame_ref[fill_f]   <= 1'b1;
              frame_dirty[fill_f] <= wr_q;
              frames_used         <= frames_used + 1'b1;
              clock_hand          <= next_frame(fill_f);
              out_valid           <= 1'b1;
              frame_no            <= fill_f;
              hit                 <= 1'b0;
              evicted             <= 1'b0;
              evict_page          <= '0;
              write_back          <= 1'b0;
              state               <= escp_pkg::ST_IDLE;
            end
          end else begin
            scan_f    <= clock_hand;
            scan_cnt  <= '0;
            scan_pass <= 2'd0;
            state     <= escp_pkg::ST_SCAN;
          end
        end
        escp_pkg::ST_SCAN: begin
          if (scan_take) begin
            victim <= scan_f;
            state  <= escp_pkg::ST_EVICT;
          end else begin
            // odd passes clear ref bits they pass over
            if (scan_pass[0]) begin
              frame_ref[scan_f] <= 1'b0;
            end
            scan_f <= next_frame(scan_f);
            if (scan_wrap) begin
              scan_cnt  <= '0;
              scan_pass <= scan_pass + 1'b1;
              if (scan_pass == 2'd3) begin
                victim <= clock_hand;
                state  <= escp_pkg::ST_EVICT;
              end
            end else begin
              scan_cnt <= scan_cnt + 1'b1;
            end
          end
        end
        escp_pkg::ST_EVICT: begin
          vic_page <= own_rd;
          vic_wb   <= frame_dirty[victim];
          state    <= escp_pkg::ST_INSTALL;
        end
        escp_pkg::ST_INSTALL: begin
          if (out_free) begin
            frame_ref[victim]   <= 1'b1;
            frame_dirty[victim] <= wr_q;
            clock_hand          <= next_frame(victim);
            out_valid           <= 1'b1;
            frame_no            <= victim;
            hit                 <= 1'b0;
            evicted             <= 1'b1;
            evict_page          <= vic_page;
            write_back          <= vic_wb;
            state               <= escp_pkg::ST_IDLE;
          end
        end
        default: state <= escp_pkg::ST_IDLE;
      endcase
    end
  end

  `ESCP_ASSERT_NOW(a_used_bound, 1'b1, frames_used <= FRAMES_W)
  `ESCP_ASSERT_NOW(a_scan_full, state == escp_pkg::ST_SCAN, frames_used == FRAMES_W)
  `ESCP_ASSERT_NOW(a_hit_frame_filled, (state == escp_pkg::ST_LOOKUP) && pm_vld,
                   (FW+1)'(pm_frame) < frames_used)
  `ESCP_ASSERT_NEXT(a_accept_lookup, accept, state == escp_pkg::ST_LOOKUP)

endmodule

FILE: verif/escp_pager_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the page map and the frame
// table, and checks every result beat against the predicted frame grant.
module escp_pager_checker #(
  parameter int FRAMES = 8,
  parameter int PAGES  = 256,
  parameter int PW     = $clog2(PAGES),
  parameter int FW     = $clog2(FRAMES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [PW-1:0] page_no,
  input  logic          is_write,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [FW-1:0] frame_no,
  input  logic          hit,
  input  logic          evicted,
  input  logic [PW-1:0] evict_page,
  input  logic          write_back,
  output int            fail_count,
  output int            outstanding
);

  typedef struct packed {
    logic [FW-1:0] frame;
    logic          hit;
    logic          evicted;
    logic [PW-1:0] victim;
    logic          write_back;
  } frame_grant_t;

  frame_grant_t  grant_q[$];

  logic          map_valid[PAGES];
  logic [FW-1:0] map_frame[PAGES];
  logic [PW-1:0] owner[FRAMES];
  logic          ref_bit[FRAMES];
  logic          dirty_bit[FRAMES];
  logic [FW-1:0] hand;
  int            frames_filled;

  function automatic logic [FW-1:0] next_frame(logic [FW-1:0] f);
    return (f == FW'(FRAMES - 1)) ? '0 : f + 1'b1;
  endfunction

  // Enhanced clock: clean scan, then dirty scan clearing ref bits, twice.
  function automatic logic [FW-1:0] choose_victim();
    logic [FW-1:0] f;
    for (int pass = 0; pass < 2; pass++) begin
      f = hand;
      for (int i = 0; i < FRAMES; i++) begin
        if (!ref_bit[f] && !dirty_bit[f]) return f;
        f = next_frame(f);
      end
      f = hand;
      for (int i = 0; i < FRAMES; i++) begin
        if (!ref_bit[f] && dirty_bit[f]) return f;
        ref_bit[f] = 1'b0;
        f = next_frame(f);
      end
    end
    return hand;
  endfunction

  function automatic frame_grant_t predict_access(logic [PW-1:0] pg, logic wr);
    frame_grant_t  r;
    logic [FW-1:0] f;
    r = '0;
    if (map_valid[pg]) begin
      f = map_frame[pg];
      ref_bit[f] = 1'b1;
      if (wr) dirty_bit[f] = 1'b1;
      r.hit = 1'b1;
    end else begin
      if (frames_filled < FRAMES) begin
        f = FW'(frames_filled);
        frames_filled++;
      end else begin
        f = choose_victim();
        r.evicted    = 1'b1;
        r.victim     = owner[f];
        r.write_back = dirty_bit[f];
        map_valid[owner[f]] = 1'b0;
      end
      owner[f]      = pg;
      ref_bit[f]    = 1'b1;
      dirty_bit[f]  = wr;
      map_valid[pg] = 1'b1;
      map_frame[pg] = f;
      hand          = next_frame(f);
    end
    r.frame = f;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_grant_t got;
    frame_grant_t want;
    if (rst) begin
      for (int p = 0; p < PAGES; p++) begin
        map_valid[p] = 1'b0;
        map_frame[p] = '0;
      end
      for (int f = 0; f < FRAMES; f++) begin
        owner[f]     = '0;
        ref_bit[f]   = 1'b0;
        dirty_bit[f] = 1'b0;
      end
      hand          = '0;
      frames_filled = 0;
      fail_count    = 0;
      grant_q.delete();
    end else begin
      if (in_valid && in_ready)
        grant_q.push_back(predict_access(page_no, is_write));
      if (out_valid && out_ready) begin
        got = {frame_no, hit, evicted, evict_page, write_back};
        if (grant_q.size() == 0) begin
          $display("%0t: result beat with no access pending, expected none, got frame %0d",
                   $time, got.frame);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          check_field("frame_no", int'(want.frame), int'(got.frame));
          check_field("hit", int'(want.hit), int'(got.hit));
          check_field("evicted", int'(want.evicted), int'(got.evicted));
          check_field("evict_page", int'(want.victim), int'(got.victim));
          check_field("write_back", int'(want.write_back), int'(got.write_back));
        end
      end
    end
    outstanding <= grant_q.size();
  end

endmodule

FILE: verif/tb_enhanced_second_chance_pager_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the pager. All prediction and checking lives in
// escp_pager_checker; this module only drives beats and decides pass/fail.
module tb_enhanced_second_chance_pager_unit;

  localparam int FRAMES          = 8;
  localparam int PAGES           = 256;
  localparam int RANDOM_ACCESSES = 1230;
  // Over ten times the slowest run: 1255 items, each with the longest idle gap,
  // full scan and receiver stall, plus the clearing pass.
  localparam int CYCLE_LIMIT     = 700000;
  // Worst single miss plus a full receiver stall.
  localparam int DRAIN_CYCLES    = 60;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] page_no;
  logic       is_write;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] frame_no;
  logic       hit;
  logic       evicted;
  logic [7:0] evict_page;
  logic       write_back;

  // When set, both sides run back to back with no idle cycles.
  logic        burst_mode;
  int          fail_count;
  int          outstanding;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  enhanced_second_chance_pager_unit #(
    .FRAMES(FRAMES),
    .PAGES (PAGES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .page_no    (page_no),
    .is_write   (is_write),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_no   (frame_no),
    .hit        (hit),
    .evicted    (evicted),
    .evict_page (evict_page),
    .write_back (write_back)
  );

  escp_pager_checker #(
    .FRAMES(FRAMES),
    .PAGES (PAGES)
  ) grant_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .page_no    (page_no),
    .is_write   (is_write),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_no   (frame_no),
    .hit        (hit),
    .evicted    (evicted),
    .evict_page (evict_page),
    .write_back (write_back),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // One access beat: optional idle gap, then hold valid and payload until
  // the beat is taken. Returns at the accepting edge, so the next call can
  // keep valid high without a drop.
  task automatic send_access(input logic [7:0] pg, input logic wr);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    page_no  <= pg;
    is_write <= wr;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Result side: per beat, an optional random stall with ready low, then take it.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [7:0] ws_base;
    logic [7:0] pg;
    logic       wr;
    int         sel;
    int         write_pct;

    rst        = 1'b1;
    in_valid   = 1'b0;
    page_no    = '0;
    is_write   = 1'b0;
    burst_mode = 1'b0;
    ws_base    = '0;
    write_pct  = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill all eight free frames, hand wraps back to frame 0. Extremes of
    // page_no and single-bit pages.
    send_access(8'd0,   1'b0);
    send_access(8'd255, 1'b1);
    send_access(8'd1,   1'b1);
    send_access(8'd2,   1'b0);
    send_access(8'd4,   1'b1);
    send_access(8'd8,   1'b0);
    send_access(8'd16,  1'b1);
    send_access(8'd32,  1'b0);
    // Write hit sets modify, read hit leaves it.
    send_access(8'd0,   1'b1);
    send_access(8'd255, 1'b0);
    // Every frame referenced: clean scan fails, dirty scan clears all
    // ref bits, second round picks the victim.
    send_access(8'd128, 1'b0);
    // Follow-on misses hit clean victims first, then dirty ones (write-back).
    send_access(8'd64,  1'b0);
    send_access(8'd170, 1'b1);
    send_access(8'd85,  1'b1);
    send_access(8'd128, 1'b1);
    send_access(8'd0,   1'b0);
    // Run of dirty loads so the table fills with modified, referenced pages.
    for (int p = 200; p < 208; p++)
      send_access(8'(p), 1'b1);
    // Miss against an all-dirty table.
    send_access(8'd199, 1'b0);

    // Random part: mostly a drifting working set a bit larger than the frame
    // count, so hits, clean evictions and write-backs all show up; the rest
    // is scattered over the whole page space.
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i % 100 == 0) begin
        ws_base   = $urandom_range(0, 255);
        write_pct = $urandom_range(0, 100);
      end
      if (i % 25 == 0)
        burst_mode <= ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 55)
        pg = ws_base + 8'($urandom_range(0, 9));
      else if (sel < 85)
        pg = ws_base + 8'($urandom_range(0, 15));
      else
        pg = 8'($urandom_range(0, 255));
      wr = ($urandom_range(0, 99) < write_pct);
      send_access(pg, wr);
    end
    in_valid <= 1'b0;

    // Let the checker see the last beat before looking at its queue.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
